/* rtl/tsps_pkg.sv */
// ----------------------------------------------------------------------------
// tsps_pkg
// Shared types, codes and saturation helpers for the trailing speed selector.
// ----------------------------------------------------------------------------
package tsps_pkg;

  localparam int PosW    = 25;  // track positions, gaps, lap length
  localparam int SpdW    = 23;  // speeds, Q7.16
  localparam int GainW   = 24;  // PID gains, Q8.16
  localparam int BlindW  = 22;
  localparam int ScaleW  = 18;
  localparam int TickW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 25;

  localparam int ErrW    = PosW + 1;       // target gap minus gap
  localparam int DspdW   = SpdW + 1;       // own minus opponent speed
  localparam int IntegW  = 21;             // holds +-10 m in Q5.16
  localparam int MulAW   = ErrW;
  localparam int MulBW   = GainW + 1;
  localparam int ProdW   = MulAW + MulBW;
  localparam int FracW   = 16;
  localparam int ShW     = ProdW - FracW;  // product after the Q16 shift
  localparam int RemCntW = 5;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_GAP   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_P       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_I       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_D       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLIND_SPEED  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RETURN_SCALE = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TICK_PERIOD  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_LAP_LENGTH   = 3'd7;

  localparam logic [1:0] OP_TRAIL  = 2'd1;
  localparam logic [1:0] OP_RETURN = 2'd2;

  localparam logic signed [ShW-1:0] S32Max   = 35'sd2147483647;
  localparam logic signed [ShW-1:0] S32Min   = -35'sd2147483648;
  localparam logic signed [ShW-1:0] CmdMax   = 35'sd4194303;
  localparam logic signed [ShW-1:0] CmdMin   = -35'sd4194304;
  localparam logic signed [ShW-1:0] IntegMax = 35'sd655360;
  localparam logic signed [ShW-1:0] IntegMin = -35'sd655360;

  typedef struct packed {
    logic [PosW-1:0]   target_gap;
    logic [GainW-1:0]  gain_p;
    logic [GainW-1:0]  gain_i;
    logic [GainW-1:0]  gain_d;
    logic [BlindW-1:0] blind_speed;
    logic [ScaleW-1:0] return_scale;
    logic [TickW-1:0]  tick_period;
    logic [PosW-1:0]   lap_length;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REM,
    ST_GAP,
    ST_ERR,
    ST_MUL_T,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_CLIP,
    ST_MUL_R,
    ST_RET,
    ST_DONE
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [ShW-1:0] v);
    logic signed [31:0] r;
    if (v > S32Max) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32Min) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [SpdW-1:0] sat_cmd(input logic signed [ShW-1:0] v);
    logic [SpdW-1:0] r;
    if (v > CmdMax) begin
      r = CmdMax[SpdW-1:0];
    end else if (v < CmdMin) begin
      r = CmdMin[SpdW-1:0];
    end else begin
      r = v[SpdW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [IntegW-1:0] clamp_integ(
      input logic signed [ShW-1:0] v);
    logic signed [IntegW-1:0] r;
    if (v > IntegMax) begin
      r = IntegMax[IntegW-1:0];
    end else if (v < IntegMin) begin
      r = IntegMin[IntegW-1:0];
    end else begin
      r = v[IntegW-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tsps_cfg.sv */
// ----------------------------------------------------------------------------
// tsps_cfg
// Configuration register file; one register written per beat.
// ----------------------------------------------------------------------------
module tsps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [tsps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tsps_pkg::CfgDatW-1:0]   cfg_data_i,
  output tsps_pkg::cfg_t                 cfg_o
);
  import tsps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_GAP:   cfg_d.target_gap   = cfg_data_i[PosW-1:0];
        CFG_GAIN_P:       cfg_d.gain_p       = cfg_data_i[GainW-1:0];
        CFG_GAIN_I:       cfg_d.gain_i       = cfg_data_i[GainW-1:0];
        CFG_GAIN_D:       cfg_d.gain_d       = cfg_data_i[GainW-1:0];
        CFG_BLIND_SPEED:  cfg_d.blind_speed  = cfg_data_i[BlindW-1:0];
        CFG_RETURN_SCALE: cfg_d.return_scale = cfg_data_i[ScaleW-1:0];
        CFG_TICK_PERIOD:  cfg_d.tick_period  = cfg_data_i[TickW-1:0];
        CFG_LAP_LENGTH:   cfg_d.lap_length   = cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_gap   <= 25'd131072;
      cfg_q.gain_p       <= '0;
      cfg_q.gain_i       <= '0;
      cfg_q.gain_d       <= '0;
      cfg_q.blind_speed  <= '0;
      cfg_q.return_scale <= 18'd65536;
      cfg_q.tick_period  <= 16'd655;
      cfg_q.lap_length   <= 25'd6553600;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/tsps_rem.sv */
// ----------------------------------------------------------------------------
// tsps_rem
// Bit-serial restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tsps_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tsps_pkg::PosW-1:0]  dividend_i,
  input  logic [tsps_pkg::PosW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [tsps_pkg::PosW-1:0]  rem_o
);
  import tsps_pkg::*;

  localparam logic [RemCntW-1:0] LastStep = RemCntW'(PosW - 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0]    shr_q, shr_d;
  logic [PosW-1:0]    rem_q, rem_d;
  logic [PosW:0]      trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shr_d  = shr_q;
    rem_d  = rem_q;
    trial  = {rem_q, shr_q[PosW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      shr_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = PosW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[PosW-1:0];
      end
      shr_d = {shr_q[PosW-2:0], 1'b0};
      cnt_d = cnt_q + RemCntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shr_q <= shr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/tsps_mul.sv */
// ----------------------------------------------------------------------------
// tsps_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tsps_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [tsps_pkg::MulAW-1:0]   a_i,
  input  logic signed [tsps_pkg::MulBW-1:0]   b_i,
  output logic signed [tsps_pkg::ProdW-1:0]   prod_o
);
  import tsps_pkg::*;

  logic signed [ProdW-1:0] prod_q, prod_d;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/trailing_speed_pid_select_unit.sv */
// ----------------------------------------------------------------------------
// trailing_speed_pid_select_unit
// Gap-following PID speed selector, Q7.16 speeds, one shared multiplier and a
// serial remainder unit under a small sequencer.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o | one control tick
//   out     | output    | out_valid_o/out_stall_i | one speed command
//   cfg     | input     | cfg_valid_i/cfg_ready_o | register index and data
//
// Trailing ticks run the bit-serial gap wrap (25 steps and a done strobe), then
// gap, error, four multiplier passes, sum and clip, and a hand-off before the
// next accept. Trailing-to-track ticks take one return-scale multiply and a
// saturation step; all others go straight to the hand-off.
// in_stall_o is high while a tick is in flight; a finished command sits in the
// output register, so the next tick may enter while it waits.
// Reset clears the gap integral and loads the register defaults.
// ----------------------------------------------------------------------------
module trailing_speed_pid_select_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic signed [tsps_pkg::SpdW-1:0]    map_speed_i,
  input  logic                                opponent_valid_i,
  input  logic                                own_track_valid_i,
  input  logic                                opponent_seen_i,
  input  logic [tsps_pkg::PosW-1:0]           opponent_pos_i,
  input  logic signed [tsps_pkg::SpdW-1:0]    opponent_speed_i,
  input  logic [tsps_pkg::PosW-1:0]           own_pos_i,
  input  logic signed [tsps_pkg::SpdW-1:0]    own_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tsps_pkg::SpdW-1:0]    speed_command_o,
  output logic [tsps_pkg::PosW-1:0]           gap_measured_o,
  output logic                                trailing_active_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tsps_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tsps_pkg::CfgDatW-1:0]        cfg_data_i
);
  import tsps_pkg::*;

  cfg_t   cfg;
  state_e state_q, state_d;

  logic in_fire, trail_ok, out_free, out_load;

  // captured tick
  logic signed [SpdW-1:0]   map_q, opp_spd_q;
  logic signed [DspdW-1:0]  dspd_q;
  logic                     seen_q, neg_q;

  // working registers
  logic [PosW-1:0]          gap_q, gap_d;
  logic signed [ErrW-1:0]   err_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [ShW-1:0]    acc_q;
  logic [SpdW-1:0]          cmd_q;
  logic                     active_q;

  // output register
  logic                     out_valid_q;
  logic [SpdW-1:0]          out_cmd_q;
  logic [PosW-1:0]          out_gap_q;
  logic                     out_active_q;

  // gap wrap
  logic signed [ErrW-1:0]   diff, ndiff;
  logic [PosW-1:0]          mag;
  logic                     rem_done;
  logic [PosW-1:0]          rem;

  // shared multiplier
  logic                     mul_en;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [ShW-1:0]    sh;
  logic signed [ShW-1:0]    term;

  logic signed [ShW-1:0]    map_x, blind_x, clip_a, clip_b, clip_c;

  assign cfg_ready_o = 1'b1;

  tsps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign trail_ok   = (operation_i == OP_TRAIL) && opponent_valid_i && own_track_valid_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && out_free;

  assign diff  = $signed({1'b0, opponent_pos_i}) - $signed({1'b0, own_pos_i});
  assign ndiff = -diff;
  assign mag   = diff[ErrW-1] ? ndiff[PosW-1:0] : diff[PosW-1:0];

  tsps_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && trail_ok),
    .dividend_i (mag),
    .divisor_i  (cfg.lap_length),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  tsps_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // floor of product / 2^16
  assign sh   = prod[ProdW-1:FracW];
  assign term = ShW'(sat32(sh));

  // wrapped gap; a negative difference folds back by the lap length, a zero lap gives zero
  always_comb begin
    if (cfg.lap_length == '0) begin
      gap_d = '0;
    end else if (neg_q && (rem != '0)) begin
      gap_d = cfg.lap_length - rem;
    end else begin
      gap_d = rem;
    end
  end

  // clip to [0, map speed], then lift to the blind speed when unseen and far
  assign map_x   = ShW'(map_q);
  assign blind_x = ShW'({1'b0, cfg.blind_speed});
  assign clip_a  = (acc_q > map_x) ? map_x : acc_q;
  assign clip_b  = (clip_a < 0) ? '0 : clip_a;
  assign clip_c  = (!seen_q && (gap_q > cfg.target_gap) && (clip_b < blind_x)) ?
                   blind_x : clip_b;

  always_comb begin
    state_d = state_q;
    mul_en  = 1'b0;
    mul_a   = err_q;
    mul_b   = MulBW'({1'b0, cfg.gain_p});
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (trail_ok) begin
            state_d = ST_REM;
          end else if (operation_i == OP_RETURN) begin
            state_d = ST_MUL_R;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_REM: begin
        if (rem_done) begin
          state_d = ST_GAP;
        end
      end
      ST_GAP: state_d = ST_ERR;
      ST_ERR: state_d = ST_MUL_T;
      ST_MUL_T: begin
        mul_en  = 1'b1;
        mul_b   = MulBW'({1'b0, cfg.tick_period});
        state_d = ST_MUL_P;
      end
      ST_MUL_P: begin
        mul_en  = 1'b1;
        state_d = ST_MUL_I;
      end
      ST_MUL_I: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(integ_q);
        mul_b   = MulBW'({1'b0, cfg.gain_i});
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(dspd_q);
        mul_b   = MulBW'({1'b0, cfg.gain_d});
        state_d = ST_SUM;
      end
      ST_SUM:  state_d = ST_CLIP;
      ST_CLIP: state_d = ST_DONE;
      ST_MUL_R: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(map_q);
        mul_b   = MulBW'({1'b0, cfg.return_scale});
        state_d = ST_RET;
      end
      ST_RET: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // gap integral: cleared in the pass-through mode, updated once per trailing tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (in_fire && !trail_ok && (operation_i != OP_RETURN)) begin
      integ_q <= '0;
    end else if (state_q == ST_MUL_P) begin
      integ_q <= clamp_integ(ShW'(integ_q) + sh);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          map_q     <= map_speed_i;
          opp_spd_q <= opponent_speed_i;
          dspd_q    <= DspdW'(own_speed_i) - DspdW'(opponent_speed_i);
          seen_q    <= opponent_seen_i;
          neg_q     <= diff[ErrW-1];
          gap_q     <= '0;
          cmd_q     <= map_speed_i;
          active_q  <= 1'b0;
        end
      end
      ST_GAP:   gap_q <= gap_d;
      ST_ERR:   err_q <= $signed({1'b0, cfg.target_gap}) - $signed({1'b0, gap_q});
      ST_MUL_I: acc_q <= ShW'(opp_spd_q) - term;
      ST_MUL_D: acc_q <= acc_q - term;
      ST_SUM:   acc_q <= acc_q - term;
      ST_CLIP: begin
        cmd_q    <= clip_c[SpdW-1:0];
        active_q <= 1'b1;
      end
      ST_RET:   cmd_q <= sat_cmd(sh);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cmd_q    <= cmd_q;
      out_gap_q    <= gap_q;
      out_active_q <= active_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign speed_command_o   = out_cmd_q;
  assign gap_measured_o    = out_gap_q;
  assign trailing_active_o = out_active_q;

endmodule
